// ----- hdl/les_pkg.sv -----
// Package with shared types, codes and constants of the LED effect sequencer.
package les_pkg;
    localparam int FACES_DEF = 6;
    localparam logic [2:0] ALL_FACES = 3'd6;

    typedef enum logic [2:0] {
        CMD_TICK = 3'd0, CMD_FLASH = 3'd1, CMD_BLINK = 3'd2, CMD_STROBE = 3'd3,
        CMD_ROTATE = 3'd4, CMD_SPIN = 3'd5, CMD_CLEAR = 3'd6, CMD_NONE = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        FX_NONE = 3'd0, FX_FLASH = 3'd1, FX_BLINK = 3'd2, FX_STROBE = 3'd3,
        FX_ROTATE = 3'd4, FX_SPIN = 3'd5, FX_UNUSED6 = 3'd6, FX_UNUSED7 = 3'd7
    } t_fx;

    typedef enum logic [2:0] {
        ST_IDLE, ST_EXEC, ST_POP, ST_OUT0, ST_OUT1
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;    // capture input word, clear write list
        logic tick;    // advance time
        logic exec;    // run the start command
        logic pop;     // pop the top entry
        logic step;    // step the top entry
    } t_ctl;

    // Status from datapath to controller.
    typedef struct packed {
        logic       is_tick;
        logic       top_done;  // stack not empty and top finished
        logic       nonempty;
        logic [1:0] wr_count;
    } t_sts;
endpackage

// ----- hdl/led_effect_sequencer_unit.sv -----
// Top level of the LED effect sequencer: controller plus datapath.
// A start command is loaded in IDLE, run in EXEC and answered in OUT0. A tick
// advances time in EXEC, then pops each finished effect and steps the top one
// in POP before its result. A new input word is taken only in IDLE, after the
// pop loop and the result hand-off in OUT0 (OUT1 for a second result word) end;
// i_ready can stall that hand-off.
// Reset (synchronous, active low) empties the stack and zeroes time and state.
module led_effect_sequencer_unit #(
    parameter int FACES = les_pkg::FACES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [15:0] i_on_color,
    input  logic [15:0] i_off_color,
    input  logic [15:0] i_on_time,
    input  logic [15:0] i_off_time,
    input  logic [15:0] i_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_write_valid,
    output logic [2:0]  o_face,
    output logic [15:0] o_color,
    output logic        o_idle,
    output logic        o_last
);
    les_pkg::t_ctl ctl;
    les_pkg::t_sts sts;
    logic          sel;

    // The controller sequences load, pop loop, step and result words.
    les_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_out_ready(i_ready), .o_out_valid(o_valid), .o_sel(sel),
        .o_last(o_last), .i_sts(sts), .o_ctl(ctl)
    );

    // The datapath holds time, the effect stack and the pending writes.
    les_dp #(.FACES(FACES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_command(i_command), .i_on_color(i_on_color),
        .i_off_color(i_off_color), .i_on_time(i_on_time),
        .i_off_time(i_off_time), .i_count(i_count), .i_sel(sel),
        .o_write_valid(o_write_valid), .o_face(o_face), .o_color(o_color),
        .o_idle(o_idle)
    );
endmodule

// ----- hdl/les_ctrl.sv -----
// Controller state machine of the LED effect sequencer.
module les_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic            o_sel,
    output logic            o_last,
    input  les_pkg::t_sts   i_sts,
    output les_pkg::t_ctl   o_ctl
);
    les_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= les_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            les_pkg::ST_IDLE: if (i_valid) n_state = les_pkg::ST_EXEC;
            les_pkg::ST_EXEC: begin
                n_state = i_sts.is_tick ? les_pkg::ST_POP : les_pkg::ST_OUT0;
            end
            les_pkg::ST_POP: begin
                if (!i_sts.top_done) n_state = les_pkg::ST_OUT0;
            end
            les_pkg::ST_OUT0: begin
                if (i_out_ready) begin
                    n_state = (i_sts.wr_count == 2'd2) ? les_pkg::ST_OUT1
                                                       : les_pkg::ST_IDLE;
                end
            end
            les_pkg::ST_OUT1: if (i_out_ready) n_state = les_pkg::ST_IDLE;
            default: n_state = les_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_ready     = 1'b0;
        o_out_valid = 1'b0;
        o_sel       = 1'b0;
        o_last      = 1'b0;
        case (r_state)
            les_pkg::ST_IDLE: begin
                o_ready  = 1'b1;
                o_ctl.load = i_valid;
            end
            les_pkg::ST_EXEC: begin
                o_ctl.tick = i_sts.is_tick;
                o_ctl.exec = !i_sts.is_tick;
            end
            les_pkg::ST_POP: begin
                o_ctl.pop  = i_sts.top_done;
                o_ctl.step = i_sts.nonempty && !i_sts.top_done;
            end
            les_pkg::ST_OUT0: begin
                o_out_valid = 1'b1;
                o_last = (i_sts.wr_count != 2'd2);
            end
            les_pkg::ST_OUT1: begin
                o_out_valid = 1'b1;
                o_sel = 1'b1;
                o_last = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ----- hdl/les_dp.sv -----
// Datapath of the LED effect sequencer: effect state, stack and write list.
module les_dp #(
    parameter int FACES = les_pkg::FACES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  les_pkg::t_ctl  i_ctl,
    output les_pkg::t_sts  o_sts,
    input  logic [2:0]     i_command,
    input  logic [15:0]    i_on_color,
    input  logic [15:0]    i_off_color,
    input  logic [15:0]    i_on_time,
    input  logic [15:0]    i_off_time,
    input  logic [15:0]    i_count,
    input  logic           i_sel,
    output logic           o_write_valid,
    output logic [2:0]     o_face,
    output logic [15:0]    o_color,
    output logic           o_idle
);
    localparam logic [3:0] FACES_C = 4'(FACES);

    logic [2:0]  r_cmd;
    logic [15:0] r_onc, r_offc, r_ont, r_offt, r_cnt;
    logic [31:0] r_time, r_flash_end, r_dot_next;
    logic [2:0]  r_stack [3];
    logic [1:0]  r_level;
    logic [15:0] r_bl_offc, r_bl_offt;
    logic        r_bl_done;
    logic [15:0] r_rep_onc, r_rep_offc, r_rep_ont, r_rep_offt, r_reps;
    logic [3:0]  r_dot_face;
    logic [15:0] r_dot_step, r_dot_onc, r_dot_offc;
    logic [1:0]  r_wcnt;
    logic [2:0]  r_wface [2];
    logic [15:0] r_wcol [2];

    logic [2:0] top;
    logic       top_done;
    assign top = (r_level != 2'd0) ? r_stack[r_level - 2'd1] : 3'd0;

    always_comb begin
        case (les_pkg::t_fx'(top))
            les_pkg::FX_FLASH:  top_done = (r_flash_end <= r_time);
            les_pkg::FX_BLINK:  top_done = r_bl_done;
            les_pkg::FX_STROBE,
            les_pkg::FX_SPIN:   top_done = (r_reps == 16'd0);
            les_pkg::FX_ROTATE: top_done = (r_dot_face > FACES_C);
            default:            top_done = 1'b1;
        endcase
    end

    assign o_sts.is_tick  = (les_pkg::t_cmd'(r_cmd) == les_pkg::CMD_TICK);
    assign o_sts.top_done = (r_level != 2'd0) && top_done;
    assign o_sts.nonempty = (r_level != 2'd0);
    assign o_sts.wr_count = r_wcnt;

    assign o_write_valid = (r_wcnt != 2'd0);
    assign o_face  = (r_wcnt == 2'd0) ? 3'd0 : r_wface[i_sel];
    assign o_color = (r_wcnt == 2'd0) ? 16'd0 : r_wcol[i_sel];
    assign o_idle  = (r_level == 2'd0);

    // Sequential effect actions performed on one exec or step cycle; each
    // block uses blocking variables to mirror the nested starts.
    always_ff @(posedge i_clk) begin
        logic [1:0]  lv;
        logic [1:0]  wc;
        logic [31:0] t;
        logic        do_flash, do_blink, do_rot, do_rstep, push_rot;
        logic [15:0] fc, fd, bon, boff, boft, ronc, roffc, rst;
        logic [3:0]  df;
        if (!i_rst_n) begin
            r_time <= '0; r_level <= '0; r_flash_end <= '0;
            r_bl_offc <= '0; r_bl_offt <= '0; r_bl_done <= 1'b0;
            r_rep_onc <= '0; r_rep_offc <= '0; r_rep_ont <= '0;
            r_rep_offt <= '0; r_reps <= '0; r_dot_face <= '0;
            r_dot_next <= '0; r_dot_step <= '0; r_dot_onc <= '0;
            r_dot_offc <= '0; r_wcnt <= '0; r_cmd <= '0;
        end else if (i_ctl.load) begin
            r_cmd <= i_command; r_onc <= i_on_color; r_offc <= i_off_color;
            r_ont <= i_on_time; r_offt <= i_off_time; r_cnt <= i_count;
            r_wcnt <= '0;
        end else if (i_ctl.tick) begin
            r_time <= r_time + 32'd1;
        end else if (i_ctl.pop) begin
            r_level <= r_level - 2'd1;
        end else if (i_ctl.exec || i_ctl.step) begin
            lv = r_level; wc = 2'd0; t = r_time;
            do_flash = 1'b0; do_blink = 1'b0; do_rot = 1'b0; do_rstep = 1'b0;
            push_rot = 1'b0;
            fc = '0; fd = '0; bon = '0; boff = '0; boft = '0;
            ronc = r_dot_onc; roffc = r_dot_offc; rst = r_dot_step;
            df = r_dot_face;
            if (i_ctl.exec) begin
                case (les_pkg::t_cmd'(r_cmd))
                    les_pkg::CMD_FLASH: begin
                        lv = 2'd0; do_flash = 1'b1; fc = r_onc; fd = r_ont;
                    end
                    les_pkg::CMD_BLINK: begin
                        lv = 2'd0; do_blink = 1'b1; bon = r_onc; fd = r_ont;
                        boff = r_offc; boft = r_offt;
                    end
                    les_pkg::CMD_STROBE: begin
                        lv = 2'd0;
                        r_rep_onc <= r_onc; r_rep_ont <= r_ont;
                        r_rep_offc <= r_offc; r_rep_offt <= r_offt;
                        r_stack[0] <= les_pkg::FX_STROBE; lv = 2'd1;
                        if (r_cnt != 16'd0) begin
                            do_blink = 1'b1; bon = r_onc; fd = r_ont;
                            boff = r_offc; boft = r_offt;
                            r_reps <= r_cnt - 16'd1;
                        end else r_reps <= r_cnt;
                    end
                    les_pkg::CMD_ROTATE: begin
                        lv = 2'd0; do_rot = 1'b1;
                        ronc = r_onc; roffc = r_offc; rst = r_ont;
                    end
                    les_pkg::CMD_SPIN: begin
                        lv = 2'd0;
                        r_rep_onc <= r_onc; r_rep_offc <= r_offc;
                        r_rep_ont <= r_ont;
                        r_stack[0] <= les_pkg::FX_SPIN; lv = 2'd1;
                        if (r_cnt != 16'd0) begin
                            do_rot = 1'b1; ronc = r_onc; roffc = r_offc;
                            rst = r_ont; r_reps <= r_cnt - 16'd1;
                        end else r_reps <= r_cnt;
                    end
                    les_pkg::CMD_CLEAR: lv = 2'd0;
                    default: ;
                endcase
            end else begin
                case (les_pkg::t_fx'(top))
                    les_pkg::FX_BLINK: begin
                        do_flash = 1'b1; fc = r_bl_offc; fd = r_bl_offt;
                        r_bl_done <= 1'b1;
                    end
                    les_pkg::FX_STROBE: begin
                        do_blink = 1'b1; bon = r_rep_onc; fd = r_rep_ont;
                        boff = r_rep_offc; boft = r_rep_offt;
                        r_reps <= r_reps - 16'd1;
                    end
                    les_pkg::FX_ROTATE: do_rstep = 1'b1;
                    les_pkg::FX_SPIN: begin
                        do_rot = 1'b1; ronc = r_rep_onc; roffc = r_rep_offc;
                        rst = r_rep_ont; r_reps <= r_reps - 16'd1;
                    end
                    default: ;
                endcase
            end
            if (do_blink) begin
                r_bl_offc <= boff; r_bl_offt <= boft; r_bl_done <= 1'b0;
                if (lv != 2'd3) begin r_stack[lv] <= les_pkg::FX_BLINK; lv = lv + 2'd1; end
                do_flash = 1'b1; fc = bon;
            end
            if (do_flash) begin
                r_wface[wc[0]] <= les_pkg::ALL_FACES; r_wcol[wc[0]] <= fc;
                wc = wc + 2'd1;
                r_flash_end <= t + {16'd0, fd};
                if (lv != 2'd3) begin r_stack[lv] <= les_pkg::FX_FLASH; lv = lv + 2'd1; end
            end
            if (do_rot) begin
                df = 4'd0; do_rstep = 1'b1; push_rot = 1'b1;
                r_dot_onc <= ronc; r_dot_offc <= roffc; r_dot_step <= rst;
            end
            if (do_rstep) begin
                if (do_rot || t >= r_dot_next) begin
                    if (df == FACES_C) begin
                        r_wface[0] <= 3'(FACES - 1); r_wcol[0] <= roffc;
                        wc = 2'd1;
                    end else begin
                        r_wface[0] <= df[2:0]; r_wcol[0] <= ronc; wc = 2'd1;
                        if (df != 4'd0) begin
                            r_wface[1] <= 3'(df - 4'd1); r_wcol[1] <= roffc;
                            wc = 2'd2;
                        end
                    end
                    df = df + 4'd1;
                    r_dot_next <= t + {16'd0, rst};
                end
                r_dot_face <= df;
            end
            if (push_rot && lv != 2'd3) begin
                r_stack[lv] <= les_pkg::FX_ROTATE; lv = lv + 2'd1;
            end
            r_level <= lv;
            r_wcnt <= wc;
        end
    end
endmodule
